/* hdl/four_channel_speed_pid_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the four-channel speed PID
// Clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_SPEED_PID_TOP_ASSERT_SVH
`define FOUR_CHANNEL_SPEED_PID_TOP_ASSERT_SVH
`ifndef SYNTH
`define FSP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define FSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define FSP_ASSERT_SAME(lbl, ante, cons)
`define FSP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/fsp_pkg.sv */
// ----------------------------------------------------------------------------
// fsp_pkg
// Widths, register indexes, reset values and shared types of the speed PID.
// ----------------------------------------------------------------------------
package fsp_pkg;

    localparam int CHANNEL_COUNT = 4;
    localparam int LANE_COUNT    = 4;

    localparam int DATA_W     = 16;
    localparam int GAIN_W     = 24;
    localparam int ILIM_W     = 31;
    localparam int DLIM_W     = 15;
    localparam int ACC_W      = 32;
    localparam int PRIOR_W    = 17;
    localparam int PKP_W      = GAIN_W + DATA_W;
    localparam int PKI_W      = GAIN_W + ACC_W;
    localparam int PKD_W      = GAIN_W + PRIOR_W;
    localparam int SUM_W      = PKI_W + 2;
    localparam int FRAC_SHIFT = 17;
    localparam int QUO_W      = SUM_W - FRAC_SHIFT;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_PROP   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_INTEG  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DIFF   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG_LIMIT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_LIMIT = 3'd4;

    localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST   = 24'sd327680;
    localparam logic signed [GAIN_W-1:0] GAIN_INTEG_RST  = 24'sd655;
    localparam logic signed [GAIN_W-1:0] GAIN_DIFF_RST   = 24'sd0;
    localparam logic [ILIM_W-1:0]        INTEG_LIMIT_RST = 31'd114514;
    localparam logic [DLIM_W-1:0]        DRIVE_LIMIT_RST = 15'd3000;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } fsp_ctl_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_prop;
        logic signed [GAIN_W-1:0] gain_integ;
        logic signed [GAIN_W-1:0] gain_diff;
        logic [ILIM_W-1:0]        integ_limit;
        logic [DLIM_W-1:0]        drive_limit;
    } fsp_cfg_t;

endpackage

/* hdl/fsp_lane.sv */
// ----------------------------------------------------------------------------
// fsp_lane
// One speed loop: error and integral update, gain products, sum, then
// truncation toward zero and output clamp.
// ----------------------------------------------------------------------------
module fsp_lane (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fsp_pkg::fsp_ctl_t                  ctl,
    input  fsp_pkg::fsp_cfg_t                  cfg,
    input  logic signed [fsp_pkg::DATA_W-1:0]  target,
    input  logic signed [fsp_pkg::DATA_W-1:0]  speed,
    output logic signed [fsp_pkg::DATA_W-1:0]  drive
);
    import fsp_pkg::*;

    logic signed [ACC_W-1:0]   accum_reg;
    logic signed [PRIOR_W-1:0] prior_reg;

    logic signed [DATA_W-1:0]  e_reg,   e_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [PRIOR_W-1:0] d_reg,   d_next;
    logic signed [PKP_W-1:0]   pkp_reg, pkp_next;
    logic signed [PKI_W-1:0]   pki_reg, pki_next;
    logic signed [PKD_W-1:0]   pkd_reg, pkd_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;

    logic signed [DATA_W:0]    diff;
    logic signed [DATA_W-1:0]  half;
    logic signed [ACC_W:0]     acc_sum;
    logic signed [ACC_W:0]     lim_pos;
    logic signed [ACC_W:0]     lim_neg;
    logic signed [SUM_W-1:0]   biased;
    logic signed [QUO_W-1:0]   quo;
    logic signed [QUO_W-1:0]   dlim_pos;
    logic signed [QUO_W-1:0]   dlim_neg;
    logic signed [QUO_W-1:0]   quo_clamped;

    // error, integral and difference
    always_comb begin
        diff = $signed({target[DATA_W-1], target}) - $signed({speed[DATA_W-1], speed});
        if (diff > 17'sd32767) begin
            e_next = 16'sh7FFF;
        end else if (diff < -17'sd32768) begin
            e_next = 16'sh8000;
        end else begin
            e_next = diff[DATA_W-1:0];
        end
        half = $signed({e_next[DATA_W-1], e_next[DATA_W-1:1]})
             + $signed({{(DATA_W-1){1'b0}}, e_next[DATA_W-1] & e_next[0]});
        acc_sum = $signed({accum_reg[ACC_W-1], accum_reg})
                + $signed({{(ACC_W+1-DATA_W){half[DATA_W-1]}}, half});
        lim_pos = $signed({{(ACC_W+1-ILIM_W){1'b0}}, cfg.integ_limit});
        lim_neg = -lim_pos;
        if (acc_sum > lim_pos) begin
            acc_next = lim_pos[ACC_W-1:0];
        end else if (acc_sum < lim_neg) begin
            acc_next = lim_neg[ACC_W-1:0];
        end else begin
            acc_next = acc_sum[ACC_W-1:0];
        end
        d_next = prior_reg - $signed({e_next[DATA_W-1], e_next});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg <= '0;
            prior_reg <= '0;
        end else if (ctl.ld1) begin
            accum_reg <= acc_next;
            prior_reg <= $signed({e_next[DATA_W-1], e_next});
        end
    end

    // gain products
    always_comb begin
        pkp_next = cfg.gain_prop  * e_reg;
        pki_next = cfg.gain_integ * acc_reg;
        pkd_next = cfg.gain_diff  * d_reg;
    end

    // sum of 2*kp*e + 2*ki*I + kd*d
    always_comb begin
        sum_next = ($signed({{(SUM_W-PKP_W){pkp_reg[PKP_W-1]}}, pkp_reg}) <<< 1)
                 + ($signed({{(SUM_W-PKI_W){pki_reg[PKI_W-1]}}, pki_reg}) <<< 1)
                 + $signed({{(SUM_W-PKD_W){pkd_reg[PKD_W-1]}}, pkd_reg});
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld1) begin
            e_reg   <= e_next;
            acc_reg <= acc_next;
            d_reg   <= d_next;
        end
        if (ctl.ld2) begin
            pkp_reg <= pkp_next;
            pki_reg <= pki_next;
            pkd_reg <= pkd_next;
        end
        if (ctl.ld3) begin
            sum_reg <= sum_next;
        end
    end

    // truncate toward zero, then clamp
    always_comb begin
        biased   = sum_reg + $signed({{(SUM_W-FRAC_SHIFT){1'b0}},
                                      {FRAC_SHIFT{sum_reg[SUM_W-1]}}});
        quo      = biased[SUM_W-1:FRAC_SHIFT];
        dlim_pos = $signed({{(QUO_W-DLIM_W){1'b0}}, cfg.drive_limit});
        dlim_neg = -dlim_pos;
        if (quo > dlim_pos) begin
            quo_clamped = dlim_pos;
        end else if (quo < dlim_neg) begin
            quo_clamped = dlim_neg;
        end else begin
            quo_clamped = quo;
        end
        drive = quo_clamped[DATA_W-1:0];
    end

endmodule

/* hdl/four_channel_speed_pid_top.sv */
// ----------------------------------------------------------------------------
// Four-channel speed PID
// Takes one transaction per cycle, while m_ready does not stall the output,
// carrying four targets and four speeds and returns one transaction of four drive
// values through the input, product, sum and output registers; the integral and
// previous-error state of each lane updates in the input stage, so back-to-back
// transactions run at full rate. The limit of the rate is that update per lane.
// ----------------------------------------------------------------------------
module four_channel_speed_pid_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [fsp_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [fsp_pkg::DATA_W-1:0]      s_target_0,
    input  logic signed [fsp_pkg::DATA_W-1:0]      s_target_1,
    input  logic signed [fsp_pkg::DATA_W-1:0]      s_target_2,
    input  logic signed [fsp_pkg::DATA_W-1:0]      s_target_3,
    input  logic signed [fsp_pkg::DATA_W-1:0]      s_speed_0,
    input  logic signed [fsp_pkg::DATA_W-1:0]      s_speed_1,
    input  logic signed [fsp_pkg::DATA_W-1:0]      s_speed_2,
    input  logic signed [fsp_pkg::DATA_W-1:0]      s_speed_3,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [fsp_pkg::DATA_W-1:0]      m_drive_0,
    output logic signed [fsp_pkg::DATA_W-1:0]      m_drive_1,
    output logic signed [fsp_pkg::DATA_W-1:0]      m_drive_2,
    output logic signed [fsp_pkg::DATA_W-1:0]      m_drive_3
);
    import fsp_pkg::*;
`include "four_channel_speed_pid_top_assert.svh"

    fsp_cfg_t cfg_reg;
    fsp_ctl_t ctl;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic mv_reg, mv_next;
    logic out_ready, ready3, ready2, ready1, out_ld;
    logic drive0_in_lim;

    logic signed [DATA_W-1:0] tgt        [LANE_COUNT];
    logic signed [DATA_W-1:0] spd        [LANE_COUNT];
    logic signed [DATA_W-1:0] lane_drive [LANE_COUNT];
    logic signed [DATA_W-1:0] drive_reg  [LANE_COUNT];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_prop   <= GAIN_PROP_RST;
            cfg_reg.gain_integ  <= GAIN_INTEG_RST;
            cfg_reg.gain_diff   <= GAIN_DIFF_RST;
            cfg_reg.integ_limit <= INTEG_LIMIT_RST;
            cfg_reg.drive_limit <= DRIVE_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_GAIN_PROP:   cfg_reg.gain_prop   <= $signed(cfg_wdata[GAIN_W-1:0]);
                REG_GAIN_INTEG:  cfg_reg.gain_integ  <= $signed(cfg_wdata[GAIN_W-1:0]);
                REG_GAIN_DIFF:   cfg_reg.gain_diff   <= $signed(cfg_wdata[GAIN_W-1:0]);
                REG_INTEG_LIMIT: cfg_reg.integ_limit <= cfg_wdata[ILIM_W-1:0];
                REG_DRIVE_LIMIT: cfg_reg.drive_limit <= cfg_wdata[DLIM_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    always_comb begin
        out_ready = !mv_reg || m_ready;
        out_ld    = v3_reg && out_ready;
        ready3    = !v3_reg || out_ready;
        ready2    = !v2_reg || ready3;
        ready1    = !v1_reg || ready2;
        s_ready   = ready1 && aresetn;
        ctl.ld1   = s_valid && s_ready;
        ctl.ld2   = v1_reg && ready2;
        ctl.ld3   = v2_reg && ready3;
        v1_next   = ctl.ld1 || (v1_reg && !ctl.ld2);
        v2_next   = ctl.ld2 || (v2_reg && !ctl.ld3);
        v3_next   = ctl.ld3 || (v3_reg && !out_ld);
        mv_next   = out_ld  || (mv_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            mv_reg <= mv_next;
        end
    end

    assign tgt[0] = s_target_0;
    assign tgt[1] = s_target_1;
    assign tgt[2] = s_target_2;
    assign tgt[3] = s_target_3;
    assign spd[0] = s_speed_0;
    assign spd[1] = s_speed_1;
    assign spd[2] = s_speed_2;
    assign spd[3] = s_speed_3;

    for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
        if (i < CHANNEL_COUNT) begin : g_on
            fsp_lane u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl),
                .cfg     (cfg_reg),
                .target  (tgt[i]),
                .speed   (spd[i]),
                .drive   (lane_drive[i])
            );
        end else begin : g_off
            assign lane_drive[i] = '0;
        end
    end

    // merge lane results into the output register
    always_ff @(posedge aclk) begin
        if (out_ld) begin
            for (int i = 0; i < LANE_COUNT; i++) begin
                drive_reg[i] <= lane_drive[i];
            end
        end
    end

    assign m_valid   = mv_reg;
    assign m_drive_0 = drive_reg[0];
    assign m_drive_1 = drive_reg[1];
    assign m_drive_2 = drive_reg[2];
    assign m_drive_3 = drive_reg[3];

    assign drive0_in_lim = (m_drive_0 <= $signed({1'b0, cfg_reg.drive_limit}))
                        && (m_drive_0 >= -$signed({1'b0, cfg_reg.drive_limit}));

    `FSP_ASSERT_NEXT(a_accept_fills_s1, ctl.ld1, v1_reg)
    `FSP_ASSERT_NEXT(a_load_shows_out, out_ld, mv_reg)
    `FSP_ASSERT_SAME(a_full_blocks_in, v1_reg && v2_reg && v3_reg && mv_reg && !m_ready, !s_ready)
    `FSP_ASSERT_SAME(a_drive_in_limit, mv_reg, drive0_in_lim)

endmodule

/* sim/four_channel_speed_pid_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-channel speed PID regression
// Drives set-point/speed transactions through the block under random source
// gaps and sink stalls, across a range of gain and limit settings, and checks
// every drive transaction against a cycle-free predictor of the four loops.
// ----------------------------------------------------------------------------
module four_channel_speed_pid_top_test;
    import fsp_pkg::*;

    typedef logic [0:LANE_COUNT-1][DATA_W-1:0] quad_t;
    typedef logic [0:LANE_COUNT-1][31:0] probe_quad_t;
    typedef struct packed {
        logic        given;
        probe_quad_t tgt;
        probe_quad_t spd;
        probe_quad_t drv;
    } probe_row_t;

    localparam int     PROBE_ROWS        = 18;
    localparam int     PHASES            = 12;
    localparam int     ITEMS_PER_PHASE   = 170;
    localparam int     WRITES_PER_PHASE  = 6;
    localparam int     SETTLE_CYCLES     = 8;
    localparam int     DRAIN_CYCLES      = 16;
    localparam longint ERR_HI            = 32767;
    localparam longint ERR_LO            = -32768;
    localparam longint GAIN_SCALE        = longint'(1) << FRAC_SHIFT;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_UNMAPPED = 3'd5;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_GAIN_PROP;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [DATA_W-1:0] s_target_0 = '0;
    logic signed [DATA_W-1:0] s_target_1 = '0;
    logic signed [DATA_W-1:0] s_target_2 = '0;
    logic signed [DATA_W-1:0] s_target_3 = '0;
    logic signed [DATA_W-1:0] s_speed_0 = '0;
    logic signed [DATA_W-1:0] s_speed_1 = '0;
    logic signed [DATA_W-1:0] s_speed_2 = '0;
    logic signed [DATA_W-1:0] s_speed_3 = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_drive_0;
    logic signed [DATA_W-1:0] m_drive_1;
    logic signed [DATA_W-1:0] m_drive_2;
    logic signed [DATA_W-1:0] m_drive_3;

    fsp_cfg_t loop_cfg = '{GAIN_PROP_RST, GAIN_INTEG_RST, GAIN_DIFF_RST,
                           INTEG_LIMIT_RST, DRIVE_LIMIT_RST};
    logic signed [ACC_W-1:0]   integ_acc [LANE_COUNT] = '{default: '0};
    logic signed [PRIOR_W-1:0] last_err  [LANE_COUNT] = '{default: '0};
    quad_t drive_due [$];
    int    faults = 0;
    int    feed_calm = 0;

    probe_row_t probe_rows [PROBE_ROWS] = '{
        '{1'b1, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
        '{1'b1, '{32767, -32768, 32767, -32768}, '{-32768, 32767, 32767, -32768},
              '{3000, -3000, 0, 0}},
        '{1'b0, '{1, -1, 3, -3}, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
        '{1'b0, '{0, 0, 100, -100}, '{1, -1, 0, 0}, '{0, 0, 0, 0}},
        '{1'b0, '{-32768, 32767, 0, -32768}, '{32767, -32768, -32768, 0},
              '{0, 0, 0, 0}},
        '{1'b0, '{12345, -12345, 32767, 1000}, '{12000, -13000, 32766, 1001},
              '{0, 0, 0, 0}},
        '{1'b0, '{-1, -1, -1, -1}, '{-1, 0, -2, 32767}, '{0, 0, 0, 0}},
        '{1'b0, '{32767, -32768, 500, -500}, '{-32768, 32767, 0, 0}, '{0, 0, 0, 0}},
        '{1'b0, '{32767, -32768, 500, -500}, '{-32768, 32767, 0, 0}, '{0, 0, 0, 0}},
        '{1'b0, '{32767, -32768, 500, -500}, '{-32768, 32767, 0, 0}, '{0, 0, 0, 0}},
        '{1'b0, '{32767, -32768, 500, -500}, '{-32768, 32767, 0, 0}, '{0, 0, 0, 0}},
        '{1'b0, '{32767, -32768, 500, -500}, '{-32768, 32767, 0, 0}, '{0, 0, 0, 0}},
        '{1'b0, '{32767, -32768, 500, -500}, '{-32768, 32767, 0, 0}, '{0, 0, 0, 0}},
        '{1'b0, '{32767, -32768, 500, -500}, '{-32768, 32767, 0, 0}, '{0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
        '{1'b0, '{-20000, 20000, 0, 0}, '{20000, -20000, 0, 0}, '{0, 0, 0, 0}},
        '{1'b0, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
        '{1'b0, '{32767, 32767, -32768, -32768}, '{32767, -32768, -32768, 32767},
              '{0, 0, 0, 0}}
    };

    four_channel_speed_pid_top uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_target_0 (s_target_0),
        .s_target_1 (s_target_1),
        .s_target_2 (s_target_2),
        .s_target_3 (s_target_3),
        .s_speed_0  (s_speed_0),
        .s_speed_1  (s_speed_1),
        .s_speed_2  (s_speed_2),
        .s_speed_3  (s_speed_3),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive_0  (m_drive_0),
        .m_drive_1  (m_drive_1),
        .m_drive_2  (m_drive_2),
        .m_drive_3  (m_drive_3)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int draw_pause(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic signed [GAIN_W-1:0] draw_gain();
        if ($urandom_range(0, 2) == 0)
            return GAIN_W'($urandom);
        return GAIN_W'(int'($urandom_range(0, 524288)) - 262144);
    endfunction

    function automatic quad_t step_speed_loops(input quad_t tgt, input quad_t spd);
        quad_t  drv;
        longint err, acc, dif, sum, quo, ilim, dlim;
        ilim = longint'(loop_cfg.integ_limit);
        dlim = longint'(loop_cfg.drive_limit);
        for (int lane = 0; lane < LANE_COUNT; lane++) begin
            if (lane >= CHANNEL_COUNT) begin
                drv[lane] = '0;
            end else begin
                err = longint'($signed(tgt[lane])) - longint'($signed(spd[lane]));
                if (err > ERR_HI) err = ERR_HI;
                else if (err < ERR_LO) err = ERR_LO;
                acc = longint'(integ_acc[lane]) + err / 2;
                if (acc > ilim) acc = ilim;
                else if (acc < -ilim) acc = -ilim;
                integ_acc[lane] = ACC_W'(acc);
                dif = longint'(last_err[lane]) - err;
                last_err[lane] = PRIOR_W'(err);
                sum = 2 * longint'($signed(loop_cfg.gain_prop)) * err
                    + 2 * longint'($signed(loop_cfg.gain_integ)) * acc
                    + longint'($signed(loop_cfg.gain_diff)) * dif;
                quo = sum / GAIN_SCALE;
                if (quo > dlim) quo = dlim;
                else if (quo < -dlim) quo = -dlim;
                drv[lane] = DATA_W'(quo);
            end
        end
        return drv;
    endfunction

    task automatic push_speeds(input quad_t tgt, input quad_t spd,
                               input logic given, input quad_t given_drv);
        int    gap;
        quad_t predicted;
        gap = draw_pause(feed_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_target_0 <= tgt[0];
        s_target_1 <= tgt[1];
        s_target_2 <= tgt[2];
        s_target_3 <= tgt[3];
        s_speed_0  <= spd[0];
        s_speed_1  <= spd[1];
        s_speed_2  <= spd[2];
        s_speed_3  <= spd[3];
        do @(posedge aclk); while (!s_ready);
        predicted = step_speed_loops(tgt, spd);
        drive_due.push_back(given ? given_drv : predicted);
    endtask

    initial begin : stimulus
        fsp_cfg_t              next_cfg;
        quad_t                 tgt, spd, given_drv;
        logic [CFG_ADDR_W-1:0] wr_idx  [WRITES_PER_PHASE];
        logic [CFG_DATA_W-1:0] wr_data [WRITES_PER_PHASE];
        int                    drift [LANE_COUNT];
        int                    base, slip, speed_i;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) begin
                for (int r = 0; r < PROBE_ROWS; r++) begin
                    for (int lane = 0; lane < LANE_COUNT; lane++) begin
                        tgt[lane]       = probe_rows[r].tgt[lane][DATA_W-1:0];
                        spd[lane]       = probe_rows[r].spd[lane][DATA_W-1:0];
                        given_drv[lane] = probe_rows[r].drv[lane][DATA_W-1:0];
                    end
                    push_speeds(tgt, spd, probe_rows[r].given, given_drv);
                end
            end else begin
                // drain the pipeline before touching the registers
                while (drive_due.size() != 0) @(posedge aclk);
                repeat (SETTLE_CYCLES) @(posedge aclk);
                case (phase)
                    1: next_cfg = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                                    31'h7FFFFFFF, 15'h7FFF};
                    2: next_cfg = '{24'sh800000, 24'sh800000, 24'sh800000,
                                    31'd0, 15'h7FFF};
                    3: next_cfg = '{draw_gain(), draw_gain(), draw_gain(),
                                    31'($urandom_range(0, 3000)), 15'd0};
                    4: next_cfg = '{GAIN_PROP_RST, 24'sd65536, 24'sd131072,
                                    31'd5000, 15'd20000};
                    default: begin
                        next_cfg.gain_prop   = draw_gain();
                        next_cfg.gain_integ  = draw_gain();
                        next_cfg.gain_diff   = draw_gain();
                        next_cfg.integ_limit = $urandom_range(0, 1) ?
                            31'($urandom) : 31'($urandom_range(0, 200000));
                        next_cfg.drive_limit = ($urandom_range(0, 2) == 0) ?
                            15'($urandom) : 15'($urandom_range(0, 4000));
                    end
                endcase
                wr_idx[0]  = REG_FIRST_UNMAPPED + 3'($urandom_range(0, 2));
                wr_data[0] = 31'($urandom);
                wr_idx[1]  = REG_GAIN_PROP;
                wr_data[1] = {7'($urandom), next_cfg.gain_prop};
                wr_idx[2]  = REG_GAIN_INTEG;
                wr_data[2] = {7'($urandom), next_cfg.gain_integ};
                wr_idx[3]  = REG_GAIN_DIFF;
                wr_data[3] = {7'($urandom), next_cfg.gain_diff};
                wr_idx[4]  = REG_INTEG_LIMIT;
                wr_data[4] = next_cfg.integ_limit;
                wr_idx[5]  = REG_DRIVE_LIMIT;
                wr_data[5] = {16'($urandom), next_cfg.drive_limit};
                for (int w = 0; w < WRITES_PER_PHASE; w++) begin
                    cfg_we    <= 1'b1;
                    cfg_addr  <= wr_idx[w];
                    cfg_wdata <= wr_data[w];
                    @(posedge aclk);
                    case (wr_idx[w])
                        REG_GAIN_PROP:   loop_cfg.gain_prop   = wr_data[w][GAIN_W-1:0];
                        REG_GAIN_INTEG:  loop_cfg.gain_integ  = wr_data[w][GAIN_W-1:0];
                        REG_GAIN_DIFF:   loop_cfg.gain_diff   = wr_data[w][GAIN_W-1:0];
                        REG_INTEG_LIMIT: loop_cfg.integ_limit = wr_data[w][ILIM_W-1:0];
                        REG_DRIVE_LIMIT: loop_cfg.drive_limit = wr_data[w][DLIM_W-1:0];
                        default: ;
                    endcase
                end
                cfg_we <= 1'b0;
            end

            for (int lane = 0; lane < LANE_COUNT; lane++)
                drift[lane] = int'($urandom_range(0, 600)) - 300;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                for (int lane = 0; lane < LANE_COUNT; lane++) begin
                    case ($urandom_range(0, 9))
                        0, 1: begin
                            tgt[lane] = DATA_W'($urandom);
                            spd[lane] = DATA_W'($urandom);
                        end
                        2: begin
                            tgt[lane] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                            spd[lane] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                        end
                        default: begin
                            base    = int'($urandom_range(0, 65535)) - 32768;
                            slip    = int'($urandom_range(0, 1200)) - 600 + drift[lane];
                            speed_i = base - slip;
                            if (speed_i > 32767) speed_i = 32767;
                            else if (speed_i < -32768) speed_i = -32768;
                            tgt[lane] = DATA_W'(base);
                            spd[lane] = DATA_W'(speed_i);
                        end
                    endcase
                end
                push_speeds(tgt, spd, 1'b0, '0);
            end
            s_valid <= 1'b0;
        end

        while (drive_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : drive_sink
        int    stall, calm;
        quad_t want, got;
        calm = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_pause(calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = {m_drive_0, m_drive_1, m_drive_2, m_drive_3};
            if (drive_due.size() == 0) begin
                $display("%0t: drive transaction with none pending, actual %h",
                         $time, got);
                faults++;
            end else begin
                want = drive_due.pop_front();
                for (int lane = 0; lane < LANE_COUNT; lane++) begin
                    if (got[lane] !== want[lane]) begin
                        $display("%0t: drive_%0d expected %0d, actual %0d", $time, lane,
                                 $signed(want[lane]), $signed(got[lane]));
                        faults++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        #1000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* four_channel_speed_pid_top.f */
+incdir+hdl
hdl/fsp_pkg.sv
hdl/fsp_lane.sv
hdl/four_channel_speed_pid_top.sv
sim/four_channel_speed_pid_top_test.sv
